>>> rtl/air_quality_index_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the air quality index block
// Shared helpers that wrap clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef AIR_QUALITY_INDEX_TOP_DEFINES_SVH
`define AIR_QUALITY_INDEX_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AQI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AQI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aqi_pkg.sv
// ----------------------------------------------------------------------------
// aqi_pkg
// Types, codes and threshold tables shared by the air quality index block.
// ----------------------------------------------------------------------------
package aqi_pkg;

  localparam int FUNC_W  = 2;
  localparam int POLL_W  = 2;
  localparam int HOUR_FW = 5;
  localparam int DAY_W   = 16;
  localparam int CONC_W  = 14;
  localparam int IDX_W   = 4;
  localparam int NSTEPS  = 9;
  localparam int THR_W   = 9;
  localparam int VAL_W   = CONC_W - 4;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  localparam logic [POLL_W-1:0] POLL_O3   = 2'd0;
  localparam logic [POLL_W-1:0] POLL_NO2  = 2'd1;
  localparam logic [POLL_W-1:0] POLL_SO2  = 2'd2;
  localparam logic [POLL_W-1:0] POLL_PM10 = 2'd3;

  localparam logic [NSTEPS*THR_W-1:0] THR_O3 =
    {9'd239, 9'd209, 9'd179, 9'd149, 9'd129, 9'd104, 9'd79, 9'd54, 9'd29};
  localparam logic [NSTEPS*THR_W-1:0] THR_NO2 =
    {9'd399, 9'd274, 9'd199, 9'd164, 9'd134, 9'd109, 9'd84, 9'd54, 9'd29};
  localparam logic [NSTEPS*THR_W-1:0] THR_SO2 =
    {9'd499, 9'd399, 9'd299, 9'd249, 9'd199, 9'd159, 9'd119, 9'd79, 9'd39};
  localparam logic [NSTEPS*THR_W-1:0] THR_PM10 =
    {9'd79, 9'd64, 9'd49, 9'd41, 9'd34, 9'd27, 9'd20, 9'd13, 9'd6};

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POLL_W-1:0]  pollutant;
    logic [HOUR_FW-1:0] hour_of_day;
    logic [DAY_W-1:0]   sample_day;
    logic [CONC_W-1:0]  concentration;
  } aqi_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  atmo_index;
    logic              no_data;
    logic [POLL_W-1:0] dominant;
  } aqi_out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } aqi_mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_SCAN,
    ST_LAST,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DECIDE
  } aqi_state_t;

  function automatic logic [IDX_W-1:0] index_of(logic [POLL_W-1:0] poll,
                                                logic [VAL_W-1:0] val);
    logic [NSTEPS*THR_W-1:0] row;
    logic [IDX_W-1:0]        idx;
    unique case (poll)
      POLL_O3:  row = THR_O3;
      POLL_NO2: row = THR_NO2;
      POLL_SO2: row = THR_SO2;
      default:  row = THR_PM10;
    endcase
    idx = IDX_W'(1);
    for (int i = 0; i < NSTEPS; i++) begin
      if (val >= VAL_W'(row[i*THR_W +: THR_W])) begin
        idx = idx + IDX_W'(1);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/air_quality_index_top.sv
// Add item on the target day with an hour below HOURS: peak read, then write back if higher.
// Other add items, clear and unused items are finished in the idle state.
// Compute item: per pollutant, a store walk and, for a pollutant with data, a division in the
// shared serial divider over SUM_W = 14 + clog2(HOURS + 1) bits; then the index decision.
// One item is in work at a time; the store walk reads one memory entry per cycle.
// Reset is synchronous; the peak store reads as zero at once through per-entry valid bits.
// ----------------------------------------------------------------------------
// air_quality_index_top
// Hourly pollutant peak store with a daily air quality index computation.
// ----------------------------------------------------------------------------
module air_quality_index_top #(
  parameter int HOURS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [aqi_pkg::DAY_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  aqi_pkg::aqi_in_t          in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output aqi_pkg::aqi_out_t         out_item
);

  localparam int HOUR_W = (HOURS > 1) ? $clog2(HOURS) : 1;
  localparam int ADDR_W = aqi_pkg::POLL_W + HOUR_W;

  aqi_pkg::aqi_mem_req_t      st_req;
  logic [ADDR_W-1:0]          st_addr;
  logic [aqi_pkg::CONC_W-1:0] st_wdata;
  logic [aqi_pkg::CONC_W-1:0] st_rdata;

  assign cfg_ready = 1'b1;

  aqi_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  aqi_ctrl #(
    .HOURS  (HOURS),
    .HOUR_W (HOUR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .st_req    (st_req),
    .st_addr   (st_addr),
    .st_wdata  (st_wdata),
    .st_rdata  (st_rdata)
  );

endmodule

>>> rtl/aqi_store.sv
// ----------------------------------------------------------------------------
// aqi_store
// Hourly peak memory with one address port, registered read data and
// per-entry valid bits so that reset and clear empty it without a walk over the entries.
// ----------------------------------------------------------------------------
`include "air_quality_index_top_defines.svh"

module aqi_store #(
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  aqi_pkg::aqi_mem_req_t      req,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [aqi_pkg::CONC_W-1:0] wdata,
  output logic [aqi_pkg::CONC_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [aqi_pkg::CONC_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic [aqi_pkg::CONC_W-1:0] mem_q_r;
  logic                       hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= wdata;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r <= valid_r[addr];
      end
    end
  end

  assign rdata = hit_r ? mem_q_r : '0;

  `AQI_ASSERT_IMPL(a_store_single_access, req.wr_en, !req.rd_en && !req.clr, "store: write overlaps read or clear")

endmodule

>>> rtl/aqi_div.sv
// ----------------------------------------------------------------------------
// aqi_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "air_quality_index_top_defines.svh"

module aqi_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  r_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;
  logic              take;

  assign shifted = {r_r, q_r[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign take    = !diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      r_r   <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r <= {q_r[NUM_W-2:0], take};
      r_r <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

  `AQI_ASSERT_IMPL(a_div_start_idle, start, !busy_r, "div: start while busy")
  `AQI_ASSERT_NEXT(a_div_start_busy, start, busy_r && !done_r, "div: start did not launch")

endmodule

>>> rtl/aqi_ctrl.sv
// ----------------------------------------------------------------------------
// aqi_ctrl
// Command sequencer: peak read-modify-write, store walk with accumulation,
// per-pollutant averaging and the final index decision.
// ----------------------------------------------------------------------------
`include "air_quality_index_top_defines.svh"

module aqi_ctrl #(
  parameter int HOURS  = 24,
  parameter int HOUR_W = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [aqi_pkg::DAY_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  aqi_pkg::aqi_in_t            in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output aqi_pkg::aqi_out_t           out_item,
  output aqi_pkg::aqi_mem_req_t       st_req,
  output logic [aqi_pkg::POLL_W+HOUR_W-1:0] st_addr,
  output logic [aqi_pkg::CONC_W-1:0]  st_wdata,
  input  logic [aqi_pkg::CONC_W-1:0]  st_rdata
);

  localparam int CNT_W  = $clog2(HOURS + 1);
  localparam int SUM_W  = aqi_pkg::CONC_W + CNT_W;
  localparam int ADDR_W = aqi_pkg::POLL_W + HOUR_W;

  aqi_pkg::aqi_state_t          state_r, state_nxt;
  logic [aqi_pkg::DAY_W-1:0]    target_day_r;
  logic [HOUR_W-1:0]            hour_r, hour_nxt;
  logic [aqi_pkg::POLL_W-1:0]   poll_r, poll_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         acc_en_r, acc_en_nxt;
  logic                         any_r, any_nxt;
  logic [ADDR_W-1:0]            addr_r, addr_nxt;
  logic [aqi_pkg::CONC_W-1:0]   conc_r, conc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  aqi_pkg::aqi_out_t            out_item_r, out_item_nxt;
  logic [aqi_pkg::CONC_W-1:0]   avg_r [4];
  logic                         avg_we;
  logic [aqi_pkg::CONC_W-1:0]   avg_val;
  logic                         clr_acc;
  logic                         adv_poll;
  logic                         div_start;
  logic                         div_done;
  logic [SUM_W-1:0]             div_quot;
  logic [HOUR_W-1:0]            in_hour;
  logic                         in_hour_ok;

  logic [aqi_pkg::CONC_W-1:0]   a1, a2;
  logic [aqi_pkg::POLL_W-1:0]   p1, p2, win;
  logic [aqi_pkg::VAL_W-1:0]    v1, v2, val;
  aqi_pkg::aqi_out_t            decision;

  aqi_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_hour    = HOUR_W'(in_item.hour_of_day);
  assign in_hour_ok = int'(in_item.hour_of_day) < HOURS;

  always_comb begin
    a1 = (avg_r[0] > avg_r[1]) ? avg_r[0] : avg_r[1];
    p1 = (avg_r[0] > avg_r[1]) ? aqi_pkg::POLL_O3 : aqi_pkg::POLL_NO2;
    a2 = (avg_r[3] > avg_r[2]) ? avg_r[3] : avg_r[2];
    p2 = (avg_r[3] > avg_r[2]) ? aqi_pkg::POLL_PM10 : aqi_pkg::POLL_SO2;
    v1 = a1[aqi_pkg::CONC_W-1:4];
    v2 = a2[aqi_pkg::CONC_W-1:4];
    win = (v1 > v2) ? p1 : p2;
    val = (v1 > v2) ? v1 : v2;
    if (any_r) begin
      decision.atmo_index = aqi_pkg::index_of(win, val);
      decision.no_data    = 1'b0;
      decision.dominant   = win;
    end else begin
      decision.atmo_index = '0;
      decision.no_data    = 1'b1;
      decision.dominant   = aqi_pkg::POLL_O3;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    hour_nxt      = hour_r;
    poll_nxt      = poll_r;
    any_nxt       = any_r;
    addr_nxt      = addr_r;
    conc_nxt      = conc_r;
    acc_en_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    st_req        = '0;
    st_addr       = addr_r;
    st_wdata      = conc_r;
    div_start     = 1'b0;
    avg_we        = 1'b0;
    avg_val       = '0;
    clr_acc       = 1'b0;
    adv_poll      = 1'b0;

    unique case (state_r)
      aqi_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_item.func)
            aqi_pkg::FUNC_ADD: begin
              if (in_item.sample_day == target_day_r && in_hour_ok) begin
                st_req.rd_en = 1'b1;
                st_addr      = {in_item.pollutant, in_hour};
                addr_nxt     = {in_item.pollutant, in_hour};
                conc_nxt     = in_item.concentration;
                state_nxt    = aqi_pkg::ST_ADD_WR;
              end
            end
            aqi_pkg::FUNC_COMPUTE: begin
              poll_nxt  = aqi_pkg::POLL_O3;
              hour_nxt  = '0;
              any_nxt   = 1'b0;
              clr_acc   = 1'b1;
              state_nxt = aqi_pkg::ST_SCAN;
            end
            aqi_pkg::FUNC_CLEAR: begin
              st_req.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      aqi_pkg::ST_ADD_WR: begin
        if (conc_r > st_rdata) begin
          st_req.wr_en = 1'b1;
        end
        state_nxt = aqi_pkg::ST_IDLE;
      end
      aqi_pkg::ST_SCAN: begin
        st_req.rd_en = 1'b1;
        st_addr      = {poll_r, hour_r};
        acc_en_nxt   = 1'b1;
        if (hour_r == HOUR_W'(HOURS - 1)) begin
          state_nxt = aqi_pkg::ST_LAST;
        end else begin
          hour_nxt = hour_r + HOUR_W'(1);
        end
      end
      aqi_pkg::ST_LAST: begin
        state_nxt = aqi_pkg::ST_DIV_GO;
      end
      aqi_pkg::ST_DIV_GO: begin
        if (cnt_r == '0) begin
          avg_we   = 1'b1;
          adv_poll = 1'b1;
        end else begin
          any_nxt   = 1'b1;
          div_start = 1'b1;
          state_nxt = aqi_pkg::ST_DIV_WAIT;
        end
      end
      aqi_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          avg_we   = 1'b1;
          avg_val  = div_quot[aqi_pkg::CONC_W-1:0];
          adv_poll = 1'b1;
        end
      end
      aqi_pkg::ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = decision;
          state_nxt     = aqi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aqi_pkg::ST_IDLE;
      end
    endcase

    if (adv_poll) begin
      if (poll_r == aqi_pkg::POLL_PM10) begin
        state_nxt = aqi_pkg::ST_DECIDE;
      end else begin
        poll_nxt  = poll_r + aqi_pkg::POLL_W'(1);
        hour_nxt  = '0;
        clr_acc   = 1'b1;
        state_nxt = aqi_pkg::ST_SCAN;
      end
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (clr_acc) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end else if (acc_en_r && st_rdata != '0) begin
      sum_nxt = sum_r + SUM_W'(st_rdata);
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aqi_pkg::ST_IDLE;
      target_day_r <= '0;
      acc_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      any_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_en_r    <= acc_en_nxt;
      out_valid_r <= out_valid_nxt;
      any_r       <= any_nxt;
      if (cfg_valid) begin
        target_day_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hour_r     <= hour_nxt;
    poll_r     <= poll_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    addr_r     <= addr_nxt;
    conc_r     <= conc_nxt;
    out_item_r <= out_item_nxt;
    if (avg_we) begin
      avg_r[poll_r] <= avg_val;
    end
  end

  assign in_stall  = (state_r != aqi_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `AQI_ASSERT_IMPL(a_ctrl_wr_in_add, st_req.wr_en, state_r == aqi_pkg::ST_ADD_WR, "ctrl: store write outside update")
  `AQI_ASSERT_IMPL(a_ctrl_done_wait, div_done, state_r == aqi_pkg::ST_DIV_WAIT, "ctrl: divider result unexpected")

endmodule

>>> tb/tb_air_quality_index_top.sv
// ----------------------------------------------------------------------------
// tb_air_quality_index_top
// Self-checking testbench for the air quality index block. A behavioral
// model of the hourly peak store predicts every index result. Directed
// tests cover the empty store, day and hour filtering, tie breaks and
// threshold edges. They are followed by phases of random sample traffic
// under several target days, with random idling on both channels and one
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_air_quality_index_top;
  import aqi_pkg::*;

  localparam int HOURS        = 24;
  localparam int NPOLL        = 4;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int ADD_SETTLE   = 8;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_ITEMS  = 235;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [DAY_W-1:0]  DAY_MAX     = 16'hFFFF;
  localparam logic [CONC_W-1:0] CONC_MAX    = 14'h3FFF;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DAY_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  aqi_in_t           in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  aqi_out_t          out_item;

  logic [CONC_W-1:0] peak_store [NPOLL][HOURS];
  logic [DAY_W-1:0]  target_day_q;
  aqi_out_t          index_q [$];
  aqi_out_t          head_index;
  int                mismatch_count = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  int                rx_hold_len = 0;

  always #10 clk = ~clk;

  air_quality_index_top #(
    .HOURS(HOURS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  function automatic logic [NSTEPS*THR_W-1:0] threshold_row(logic [POLL_W-1:0] poll);
    case (poll)
      POLL_O3:  return THR_O3;
      POLL_NO2: return THR_NO2;
      POLL_SO2: return THR_SO2;
      default:  return THR_PM10;
    endcase
  endfunction

  function automatic aqi_out_t predict_index();
    int unsigned             avg [NPOLL];
    int unsigned             sum;
    int unsigned             cnt;
    int unsigned             v1;
    int unsigned             v2;
    int unsigned             val;
    bit                      any;
    logic [POLL_W-1:0]       p1;
    logic [POLL_W-1:0]       p2;
    logic [POLL_W-1:0]       win;
    logic [NSTEPS*THR_W-1:0] row;
    aqi_out_t                r;
    any = 1'b0;
    for (int p = 0; p < NPOLL; p++) begin
      sum = 0;
      cnt = 0;
      for (int h = 0; h < HOURS; h++) begin
        if (peak_store[p][h] != '0) begin
          sum += peak_store[p][h];
          cnt++;
        end
      end
      avg[p] = (cnt != 0) ? sum / cnt : 0;
      if (cnt != 0) begin
        any = 1'b1;
      end
    end
    if (!any) begin
      r.atmo_index = '0;
      r.no_data    = 1'b1;
      r.dominant   = POLL_O3;
      return r;
    end
    p1 = (avg[POLL_O3] > avg[POLL_NO2]) ? POLL_O3 : POLL_NO2;
    p2 = (avg[POLL_PM10] > avg[POLL_SO2]) ? POLL_PM10 : POLL_SO2;
    v1 = avg[p1] >> 4;
    v2 = avg[p2] >> 4;
    win = (v1 > v2) ? p1 : p2;
    val = (v1 > v2) ? v1 : v2;
    row = threshold_row(win);
    r.atmo_index = IDX_W'(1);
    for (int i = 0; i < NSTEPS; i++) begin
      if (val >= row[i*THR_W +: THR_W]) begin
        r.atmo_index = r.atmo_index + IDX_W'(1);
      end
    end
    r.no_data  = 1'b0;
    r.dominant = win;
    return r;
  endfunction

  task automatic clear_store();
    for (int p = 0; p < NPOLL; p++) begin
      for (int h = 0; h < HOURS; h++) begin
        peak_store[p][h] = '0;
      end
    end
  endtask

  task automatic apply_item(input aqi_in_t it);
    case (it.func)
      FUNC_ADD: begin
        if (it.sample_day == target_day_q && it.hour_of_day < HOURS &&
            it.concentration > peak_store[it.pollutant][it.hour_of_day]) begin
          peak_store[it.pollutant][it.hour_of_day] = it.concentration;
        end
      end
      FUNC_CLEAR: begin
        clear_store();
      end
      FUNC_COMPUTE: begin
        index_q.insert(index_q.size(), predict_index());
      end
      default: begin
      end
    endcase
  endtask

  function automatic aqi_in_t make_item(logic [FUNC_W-1:0] func, logic [POLL_W-1:0] poll,
                                        logic [HOUR_FW-1:0] hour, logic [DAY_W-1:0] day,
                                        logic [CONC_W-1:0] conc);
    aqi_in_t it;
    it.func          = func;
    it.pollutant     = poll;
    it.hour_of_day   = hour;
    it.sample_day    = day;
    it.concentration = conc;
    return it;
  endfunction

  function automatic aqi_in_t random_item(logic [DAY_W-1:0] day);
    aqi_in_t     it;
    int unsigned pick;
    int unsigned top;
    it = make_item(FUNC_ADD, POLL_W'($urandom_range(3)), HOUR_FW'($urandom_range(23)), day,
                   '0);
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.func = FUNC_COMPUTE;
    end else if (pick < 8) begin
      it.func = FUNC_CLEAR;
    end else if (pick < 9) begin
      it = aqi_in_t'($urandom);
      it.func = FUNC_UNUSED;
    end
    if ($urandom_range(99) < 15) begin
      it.sample_day = DAY_W'($urandom_range(65535));
    end
    if ($urandom_range(99) < 8) begin
      it.hour_of_day = HOUR_FW'($urandom_range(31));
    end
    case (it.pollutant)
      POLL_O3:  top = 4200;
      POLL_NO2: top = 6900;
      POLL_SO2: top = 8600;
      default:  top = 1500;
    endcase
    pick = $urandom_range(9);
    if (pick == 0) begin
      it.concentration = CONC_W'($urandom_range(16383));
    end else if (pick == 1) begin
      it.concentration = '0;
    end else begin
      it.concentration = CONC_W'($urandom_range(top));
    end
    return it;
  endfunction

  // The valid is left high after acceptance; the next call decides whether to idle.
  task automatic send_item(input aqi_in_t it);
    while (!tx_calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    apply_item(it);
  endtask

  // An add item may still be in flight with nothing expected, so settle first.
  task automatic write_target_day(input logic [DAY_W-1:0] day);
    in_valid <= 1'b0;
    while (index_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (ADD_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= day;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    target_day_q = day;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_store();
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
    send_item(make_item(FUNC_UNUSED, POLL_PM10, 5'd31, DAY_MAX, CONC_MAX));
    send_item(make_item(FUNC_CLEAR, POLL_O3, '0, '0, '0));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
  endtask

  task automatic test_day_and_hour_filter();
    write_target_day(DAY_MAX);
    send_item(make_item(FUNC_ADD, POLL_O3, 5'd23, DAY_MAX, CONC_MAX));
    send_item(make_item(FUNC_ADD, POLL_NO2, 5'd0, 16'hFFFE, CONC_MAX));
    send_item(make_item(FUNC_ADD, POLL_SO2, 5'd24, DAY_MAX, CONC_MAX));
    send_item(make_item(FUNC_ADD, POLL_PM10, 5'd31, DAY_MAX, CONC_MAX));
    send_item(make_item(FUNC_ADD, POLL_PM10, 5'd5, DAY_MAX, '0));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
    // A lower sample must not pull the stored peak down.
    send_item(make_item(FUNC_ADD, POLL_O3, 5'd23, DAY_MAX, 14'd100));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
  endtask

  task automatic test_tie_breaks();
    send_item(make_item(FUNC_CLEAR, POLL_O3, '0, '0, '0));
    write_target_day('0);
    send_item(make_item(FUNC_ADD, POLL_O3, 5'd0, '0, 14'd800));
    send_item(make_item(FUNC_ADD, POLL_NO2, 5'd1, '0, 14'd800));
    send_item(make_item(FUNC_ADD, POLL_SO2, 5'd2, '0, 14'd800));
    send_item(make_item(FUNC_ADD, POLL_PM10, 5'd3, '0, 14'd800));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
  endtask

  task automatic test_threshold_edges();
    send_item(make_item(FUNC_CLEAR, POLL_O3, '0, '0, '0));
    send_item(make_item(FUNC_ADD, POLL_PM10, 5'd0, '0, 14'd96));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
    send_item(make_item(FUNC_ADD, POLL_PM10, 5'd1, '0, 14'd1264));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
    send_item(make_item(FUNC_ADD, POLL_PM10, 5'd2, '0, 14'd15));
    send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
  endtask

  task automatic test_random_traffic();
    logic [DAY_W-1:0] day;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        day = '0;
      end else if (ph == 1) begin
        day = DAY_MAX;
      end else begin
        day = DAY_W'($urandom_range(65535));
      end
      write_target_day(day);
      tx_calm = (ph == 3);
      rx_calm = (ph == 3);
      repeat (PHASE_ITEMS) send_item(random_item(day));
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_output_backpressure();
    rx_hold_len = 1000;
    tx_calm = 1'b1;
    repeat (6) begin
      send_item(make_item(FUNC_COMPUTE, POLL_O3, '0, '0, '0));
      send_item(random_item(target_day_q));
    end
    tx_calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (index_q.size() == 0) begin
        $display("%0t: result with none expected: actual index %0d no_data %0b dominant %0d",
                 $time, out_item.atmo_index, out_item.no_data, out_item.dominant);
        mismatch_count++;
      end else begin
        head_index = index_q.pop_front();
        if (out_item.atmo_index != head_index.atmo_index ||
            out_item.no_data != head_index.no_data ||
            out_item.dominant != head_index.dominant) begin
          $display("%0t: expected index %0d no_data %0b dominant %0d, actual %0d %0b %0d",
                   $time, head_index.atmo_index, head_index.no_data, head_index.dominant,
                   out_item.atmo_index, out_item.no_data, out_item.dominant);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : rx_stall_gen
    int hold;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end else begin
        out_stall <= !rx_calm && ($urandom_range(99) < 33);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[air_quality_index_top] ERROR");
    $finish;
  end

  initial begin
    clear_store();
    target_day_q = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_store();
    test_day_and_hour_filter();
    test_tie_breaks();
    test_threshold_edges();
    test_random_traffic();
    test_output_backpressure();
    in_valid <= 1'b0;
    while (index_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[air_quality_index_top] OK");
    end else begin
      $display("[air_quality_index_top] ERROR");
    end
    $finish;
  end

endmodule
